FILE: rtl/core/incremental_pid_controller_macros.svh
// Assertion macros shared by the controller RTL.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef INCREMENTAL_PID_CONTROLLER_MACROS_SVH
`define INCREMENTAL_PID_CONTROLLER_MACROS_SVH

// same-cycle implication
`define IPID_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define IPID_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/ipid_pkg.sv
// Shared types and constants of the incremental PID controller.
// No dependencies; used by every module in rtl/core.
package ipid_pkg;

	localparam int DATA_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;
	localparam int CFG_IDX_W      = 3;
	// 2*kd/dt is formed by a left shift
	localparam int DERIV_SHIFT    = 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN_PROP  = 3'd0,
		REG_GAIN_INTEG = 3'd1,
		REG_GAIN_DERIV = 3'd2,
		REG_STEP_TIME  = 3'd3,
		REG_SETPOINT   = 3'd4
	} reg_idx_t;

	typedef enum logic {
		OP_MUL = 1'b0,
		OP_DIV = 1'b1
	} op_t;

	// operand set fed to the iterative unit
	typedef enum logic [2:0] {
		SEL_DIV = 3'd0,
		SEL_IDT = 3'd1,
		SEL_C0  = 3'd2,
		SEL_C1  = 3'd3,
		SEL_C2  = 3'd4
	} sel_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV_GO,
		ST_DIV_RUN,
		ST_IDT_GO,
		ST_IDT_RUN,
		ST_COEF,
		ST_T0_GO,
		ST_T0_RUN,
		ST_T1_GO,
		ST_T1_RUN,
		ST_T2_GO,
		ST_T2_RUN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic busy;
		logic load_in;
		logic start;
		op_t  op;
		sel_t sel;
		logic cap_q;
		logic cap_idt;
		logic cap_coef;
		logic acc_add;
		logic commit;
	} ctrl_t;

endpackage

FILE: rtl/core/ipid_iter_unit.sv
// Bit-serial shift-add multiplier / restoring divider around one shared adder.
// Depends on ipid_pkg (ctrl_t, op_t).
module ipid_iter_unit #(
	parameter int DATA_WIDTH = ipid_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = ipid_pkg::FRAC_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  ipid_pkg::ctrl_t                  ctrl,
	input  logic [DATA_WIDTH+FRAC_BITS-1:0]  opa,
	input  logic [DATA_WIDTH-1:0]            opb,
	output logic                             busy,
	output logic                             done,
	output logic [2*DATA_WIDTH-1:0]          prod,
	output logic [DATA_WIDTH+FRAC_BITS-1:0]  quot
);

	localparam int NW = DATA_WIDTH + FRAC_BITS;
	localparam int CW = $clog2(NW + 1);

	logic [DATA_WIDTH-1:0] hi_q;
	logic [NW-1:0]         lo_q;
	logic [DATA_WIDTH-1:0] opb_q;
	ipid_pkg::op_t         op_q;
	logic [CW-1:0]         cnt_q;
	logic                  busy_q;
	logic                  done_q;

	logic                  is_div;
	logic [DATA_WIDTH:0]   add_x;
	logic [DATA_WIDTH:0]   add_y;
	logic [DATA_WIDTH+1:0] sum;
	logic [CW-1:0]         last;

	// divide: trial subtract of the divisor from {remainder, next dividend bit}
	// multiply: add multiplicand into the high half when the multiplier lsb is set
	assign is_div = (op_q == ipid_pkg::OP_DIV);
	assign add_x  = is_div ? {hi_q, lo_q[NW-1]} : {1'b0, hi_q};
	assign add_y  = (is_div || lo_q[0]) ? {1'b0, opb_q} : '0;
	assign sum    = {1'b0, add_x} + {1'b0, (is_div ? ~add_y : add_y)}
	                + (DATA_WIDTH+2)'(is_div);
	assign last   = is_div ? CW'(NW - 1) : CW'(DATA_WIDTH - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (ctrl.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == last);
			if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == last)
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			hi_q  <= '0;
			lo_q  <= opa;
			opb_q <= opb;
			op_q  <= ctrl.op;
		end else if (busy_q) begin
			if (is_div) begin
				// carry out set: no borrow, quotient bit is one
				hi_q <= sum[DATA_WIDTH+1] ? sum[DATA_WIDTH-1:0] : add_x[DATA_WIDTH-1:0];
				lo_q <= {lo_q[NW-2:0], sum[DATA_WIDTH+1]};
			end else begin
				hi_q <= sum[DATA_WIDTH:1];
				lo_q <= NW'({sum[0], lo_q[DATA_WIDTH-1:1]});
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign prod = {hi_q, lo_q[DATA_WIDTH-1:0]};
	assign quot = lo_q;

endmodule

FILE: rtl/core/ipid_seq.sv
// Sequencer: steps one item through divide, four multiplies and the final sum.
// Depends on ipid_pkg (state_t, ctrl_t).
module ipid_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            unit_done,
	input  logic            out_free,
	output ipid_pkg::ctrl_t ctrl
);

	ipid_pkg::state_t state_q;
	ipid_pkg::state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ipid_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ipid_pkg::ST_IDLE:    if (in_valid) state_nxt = ipid_pkg::ST_DIV_GO;
			ipid_pkg::ST_DIV_GO:  state_nxt = ipid_pkg::ST_DIV_RUN;
			ipid_pkg::ST_DIV_RUN: if (unit_done) state_nxt = ipid_pkg::ST_IDT_GO;
			ipid_pkg::ST_IDT_GO:  state_nxt = ipid_pkg::ST_IDT_RUN;
			ipid_pkg::ST_IDT_RUN: if (unit_done) state_nxt = ipid_pkg::ST_COEF;
			ipid_pkg::ST_COEF:    state_nxt = ipid_pkg::ST_T0_GO;
			ipid_pkg::ST_T0_GO:   state_nxt = ipid_pkg::ST_T0_RUN;
			ipid_pkg::ST_T0_RUN:  if (unit_done) state_nxt = ipid_pkg::ST_T1_GO;
			ipid_pkg::ST_T1_GO:   state_nxt = ipid_pkg::ST_T1_RUN;
			ipid_pkg::ST_T1_RUN:  if (unit_done) state_nxt = ipid_pkg::ST_T2_GO;
			ipid_pkg::ST_T2_GO:   state_nxt = ipid_pkg::ST_T2_RUN;
			ipid_pkg::ST_T2_RUN:  if (unit_done) state_nxt = ipid_pkg::ST_DONE;
			ipid_pkg::ST_DONE:    if (out_free) state_nxt = ipid_pkg::ST_IDLE;
			default:              state_nxt = ipid_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl      = '0;
		ctrl.op   = ipid_pkg::OP_MUL;
		ctrl.sel  = ipid_pkg::SEL_DIV;
		ctrl.busy = (state_q != ipid_pkg::ST_IDLE);
		case (state_q)
			ipid_pkg::ST_IDLE: begin
				ctrl.load_in = in_valid;
			end
			ipid_pkg::ST_DIV_GO: begin
				ctrl.start = 1'b1;
				ctrl.op    = ipid_pkg::OP_DIV;
			end
			ipid_pkg::ST_DIV_RUN: begin
				ctrl.cap_q = unit_done;
			end
			ipid_pkg::ST_IDT_GO: begin
				ctrl.start = 1'b1;
				ctrl.sel   = ipid_pkg::SEL_IDT;
			end
			ipid_pkg::ST_IDT_RUN: begin
				ctrl.sel     = ipid_pkg::SEL_IDT;
				ctrl.cap_idt = unit_done;
			end
			ipid_pkg::ST_COEF: begin
				ctrl.cap_coef = 1'b1;
			end
			ipid_pkg::ST_T0_GO: begin
				ctrl.start = 1'b1;
				ctrl.sel   = ipid_pkg::SEL_C0;
			end
			ipid_pkg::ST_T0_RUN: begin
				ctrl.sel     = ipid_pkg::SEL_C0;
				ctrl.acc_add = unit_done;
			end
			ipid_pkg::ST_T1_GO: begin
				ctrl.start = 1'b1;
				ctrl.sel   = ipid_pkg::SEL_C1;
			end
			ipid_pkg::ST_T1_RUN: begin
				ctrl.sel     = ipid_pkg::SEL_C1;
				ctrl.acc_add = unit_done;
			end
			ipid_pkg::ST_T2_GO: begin
				ctrl.start = 1'b1;
				ctrl.sel   = ipid_pkg::SEL_C2;
			end
			ipid_pkg::ST_T2_RUN: begin
				ctrl.sel     = ipid_pkg::SEL_C2;
				ctrl.acc_add = unit_done;
			end
			ipid_pkg::ST_DONE: begin
				ctrl.commit = out_free;
			end
			default: begin
				ctrl.busy = 1'b1;
			end
		endcase
	end

endmodule

FILE: rtl/core/incremental_pid_controller.sv
// Incremental (velocity-form) PID controller top level: config registers, error
// history, coefficient and accumulator datapath. Uses ipid_pkg, ipid_seq, ipid_iter_unit.
//
//  channel  direction  handshake            payload
//  in       sink       in_valid / in_stall  measured
//  out      source     out_valid/out_stall  drive, clipped
//  cfg      sink       cfg_valid/cfg_ready  cfg_index, cfg_data
//
// From acceptance to result, each item goes through the one-bit-per-cycle
// shift-add/subtract unit that runs the kd/dt divide and the four multiplies in turn,
// and in_stall is high meanwhile, so a new item waits until the last is committed.
// A finished result sits in the output register; the next item is taken while it
// waits, and only its commit waits for out_stall. cfg_ready is always high.
// Reset: gains and setpoint zero, step time 1.0, error history and drive zero.
`include "incremental_pid_controller_macros.svh"

module incremental_pid_controller #(
	parameter int DATA_WIDTH = ipid_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = ipid_pkg::FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic signed [DATA_WIDTH-1:0]   measured,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic signed [DATA_WIDTH-1:0]   drive,
	output logic                           clipped,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [ipid_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [DATA_WIDTH-1:0]          cfg_data
);

	localparam int NW = DATA_WIDTH + FRAC_BITS;
	localparam int SW = 2*DATA_WIDTH + FRAC_BITS + 2;
	localparam logic [DATA_WIDTH-1:0] D_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam logic [DATA_WIDTH-1:0] D_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

	function automatic logic fits(input logic signed [SW-1:0] x);
		return (x[SW-1:DATA_WIDTH-1] == '0) || (x[SW-1:DATA_WIDTH-1] == '1);
	endfunction

	function automatic logic [DATA_WIDTH-1:0] sat_w(input logic signed [SW-1:0] x);
		logic [DATA_WIDTH-1:0] r;
		if (fits(x))
			r = x[DATA_WIDTH-1:0];
		else
			r = x[SW-1] ? D_MIN : D_MAX;
		return r;
	endfunction

	function automatic logic [DATA_WIDTH-1:0] mag(input logic [DATA_WIDTH-1:0] v);
		return v[DATA_WIDTH-1] ? (~v + DATA_WIDTH'(1)) : v;
	endfunction

	// configuration
	logic signed [DATA_WIDTH-1:0] gain_prop_q;
	logic signed [DATA_WIDTH-1:0] gain_integ_q;
	logic signed [DATA_WIDTH-1:0] gain_deriv_q;
	logic        [DATA_WIDTH-1:0] step_time_q;
	logic signed [DATA_WIDTH-1:0] setpoint_q;

	// state and working registers
	logic signed [DATA_WIDTH-1:0] err0_q;
	logic signed [DATA_WIDTH-1:0] err1_q;
	logic signed [DATA_WIDTH-1:0] err2_q;
	logic signed [DATA_WIDTH-1:0] drv_q;
	logic                         clip_q;
	logic                         out_valid_q;
	logic signed [DATA_WIDTH-1:0] q_q;
	logic signed [DATA_WIDTH-1:0] idt_q;
	logic signed [DATA_WIDTH-1:0] c0_q;
	logic signed [DATA_WIDTH-1:0] c1_q;
	logic signed [SW-1:0]         acc_q;

	ipid_pkg::ctrl_t              ctrl;
	logic                         out_free;
	logic                         unit_busy;
	logic                         unit_done;
	logic [2*DATA_WIDTH-1:0]      prod;
	logic [NW-1:0]                quot;
	logic [NW-1:0]                opa;
	logic [DATA_WIDTH-1:0]        opb;
	logic                         neg;
	logic [DATA_WIDTH-1:0]        dt_eff;
	logic signed [SW-1:0]         err_full;
	logic signed [SW-1:0]         prod_ext;
	logic signed [SW-1:0]         quot_ext;
	logic signed [SW-1:0]         term_sh;
	logic signed [SW-1:0]         q_full;
	logic signed [SW-1:0]         c0_full;
	logic signed [SW-1:0]         c1_full;

	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = ctrl.busy;
	assign out_valid = out_valid_q;
	assign drive     = drv_q;
	assign clipped   = clip_q;

	// a zero step time acts as the smallest interval
	assign dt_eff = (step_time_q == '0) ? DATA_WIDTH'(1) : step_time_q;

	always_comb begin
		opa = '0;
		opb = '0;
		neg = 1'b0;
		case (ctrl.sel)
			ipid_pkg::SEL_DIV: begin
				opa = {mag(gain_deriv_q), {FRAC_BITS{1'b0}}};
				opb = dt_eff;
				neg = gain_deriv_q[DATA_WIDTH-1];
			end
			ipid_pkg::SEL_IDT: begin
				opa = NW'(dt_eff);
				opb = mag(gain_integ_q);
				neg = gain_integ_q[DATA_WIDTH-1];
			end
			ipid_pkg::SEL_C0: begin
				opa = NW'(mag(err0_q));
				opb = mag(c0_q);
				neg = c0_q[DATA_WIDTH-1] ^ err0_q[DATA_WIDTH-1];
			end
			ipid_pkg::SEL_C1: begin
				opa = NW'(mag(err1_q));
				opb = mag(c1_q);
				neg = c1_q[DATA_WIDTH-1] ^ err1_q[DATA_WIDTH-1];
			end
			ipid_pkg::SEL_C2: begin
				opa = NW'(mag(err2_q));
				opb = mag(q_q);
				neg = q_q[DATA_WIDTH-1] ^ err2_q[DATA_WIDTH-1];
			end
			default: begin
				neg = 1'b0;
			end
		endcase
	end

	always_comb begin
		err_full = SW'(setpoint_q) - SW'(measured);
		prod_ext = SW'($signed({1'b0, prod}));
		quot_ext = SW'($signed({1'b0, quot}));
		// floor shift of the signed product
		term_sh  = (neg ? -prod_ext : prod_ext) >>> FRAC_BITS;
		q_full   = neg ? -quot_ext : quot_ext;
		c0_full  = SW'(gain_prop_q) + SW'(q_q) + SW'(idt_q);
		c1_full  = -SW'(gain_prop_q) - (SW'(q_q) <<< ipid_pkg::DERIV_SHIFT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_prop_q  <= '0;
			gain_integ_q <= '0;
			gain_deriv_q <= '0;
			step_time_q  <= DATA_WIDTH'(1) << FRAC_BITS;
			setpoint_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				ipid_pkg::REG_GAIN_PROP:  gain_prop_q  <= cfg_data;
				ipid_pkg::REG_GAIN_INTEG: gain_integ_q <= cfg_data;
				ipid_pkg::REG_GAIN_DERIV: gain_deriv_q <= cfg_data;
				ipid_pkg::REG_STEP_TIME:  step_time_q  <= cfg_data;
				ipid_pkg::REG_SETPOINT:   setpoint_q   <= cfg_data;
				default:                  ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err1_q      <= '0;
			err2_q      <= '0;
			drv_q       <= '0;
			clip_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (ctrl.commit) begin
			drv_q       <= sat_w(acc_q);
			clip_q      <= !fits(acc_q);
			err2_q      <= err1_q;
			err1_q      <= err0_q;
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load_in)
			err0_q <= sat_w(err_full);
		if (ctrl.cap_q)
			q_q <= sat_w(q_full);
		if (ctrl.cap_idt)
			idt_q <= sat_w(term_sh);
		if (ctrl.cap_coef) begin
			c0_q  <= sat_w(c0_full);
			c1_q  <= sat_w(c1_full);
			acc_q <= SW'(drv_q);
		end else if (ctrl.acc_add) begin
			acc_q <= acc_q + term_sh;
		end
	end

	ipid_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.unit_done (unit_done),
		.out_free  (out_free),
		.ctrl      (ctrl)
	);

	ipid_iter_unit #(
		.DATA_WIDTH (DATA_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_unit (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.opa    (opa),
		.opb    (opb),
		.busy   (unit_busy),
		.done   (unit_done),
		.prod   (prod),
		.quot   (quot)
	);

	`IPID_ASSERT_NOW(a_commit_free, ctrl.commit, !out_valid_q || !out_stall, "commit over a held result")
	`IPID_ASSERT_NOW(a_idle_unit, !in_stall, !unit_busy, "ready while the unit runs")
	`IPID_ASSERT_NOW(a_start_idle, ctrl.start, !unit_busy, "unit restarted while busy")
	`IPID_ASSERT_NEXT(a_commit_valid, ctrl.commit, out_valid_q, "committed item not shown")

endmodule
